// ===== hw/rtl/hpu_pkg.sv =====
// shared types, constants and step functions for the homing particle update
`timescale 1ns / 1ps
package hpu_pkg;

	localparam int FRAC_BITS = 16;
	// squared speed at or below this counts as stationary (1e-6 in the squared scale)
	localparam logic [63:0] STILL_LIMIT = (64'd1 << (2 * FRAC_BITS)) / 64'd1000000;
	localparam logic [12:0] STEP_MAX = 13'd4096;

	localparam int ROOT_STEPS = 35;
	localparam int RAD_W      = 2 * ROOT_STEPS;
	localparam int ROOT_W     = ROOT_STEPS;
	localparam int REM_W      = ROOT_STEPS + 3;
	localparam int LEN_W      = 34;
	localparam int NUM_W      = 65;
	localparam int DIV_STEPS  = 32;

	typedef enum logic [2:0] {
		REG_DEST_X,
		REG_DEST_Y,
		REG_DEST_Z,
		REG_DIE_DIST,
		REG_TIME_STEP
	} reg_index_t;

	typedef enum logic [1:0] {
		ST_KEPT    = 2'd0,
		ST_ARRIVED = 2'd1,
		ST_STILL   = 2'd2
	} status_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] vel_z;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] new_pos_x;
		logic signed [31:0] new_pos_y;
		logic signed [31:0] new_pos_z;
		logic signed [31:0] new_vel_x;
		logic signed [31:0] new_vel_y;
		logic signed [31:0] new_vel_z;
		status_t            status;
	} out_item_t;

	// one digit of a restoring square root
	typedef struct packed {
		logic [RAD_W-1:0]  rad;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} root_state_t;

	// one bit of a restoring long division
	typedef struct packed {
		logic [DIV_STEPS-1:0] num;
		logic [LEN_W-1:0]     rem;
		logic [LEN_W-1:0]     den;
		logic [DIV_STEPS-1:0] quo;
	} div_state_t;

	function automatic root_state_t root_step(root_state_t s);
		root_state_t r;
		logic [REM_W-1:0] cur;
		logic [REM_W-1:0] trial;
		cur   = {s.rem[REM_W-3:0], s.rad[RAD_W-1 -: 2]};
		trial = {1'b0, s.root, 2'b01};
		r.rad = {s.rad[RAD_W-3:0], 2'b00};
		if (cur >= trial) begin
			r.rem  = cur - trial;
			r.root = {s.root[ROOT_W-2:0], 1'b1};
		end else begin
			r.rem  = cur;
			r.root = {s.root[ROOT_W-2:0], 1'b0};
		end
		return r;
	endfunction

	function automatic div_state_t div_step(div_state_t s);
		div_state_t r;
		logic [LEN_W:0] cur;
		cur   = {s.rem, s.num[DIV_STEPS-1]};
		r.num = {s.num[DIV_STEPS-2:0], 1'b0};
		r.den = s.den;
		if (cur >= {1'b0, s.den}) begin
			r.rem = LEN_W'(cur - {1'b0, s.den});
			r.quo = {s.quo[DIV_STEPS-2:0], 1'b1};
		end else begin
			r.rem = cur[LEN_W-1:0];
			r.quo = {s.quo[DIV_STEPS-2:0], 1'b0};
		end
		return r;
	endfunction

	// saturate a 34 bit signed value to 32 bits
	function automatic logic [31:0] sat32(logic signed [33:0] v);
		logic [31:0] r;
		if (v > 34'sh0_7FFF_FFFF) begin
			r = 32'h7FFF_FFFF;
		end else if (v < -34'sh0_8000_0000) begin
			r = 32'h8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/homing_particle_update.sv =====
// homing particle update: top level pipeline
// pipeline stages: 3 front stages, 35 square root stages, 1 product stage,
// 32 divider stages, 3 back stages
// throughput: one item per cycle; the whole pipeline holds while the output
// register is full and stalled
// reset: all valid bits clear, configuration registers return to their reset values
`timescale 1ns / 1ps
module homing_particle_update (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  hpu_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_stall,
	output hpu_pkg::out_item_t out_item,
	input  logic               wr_en,
	input  logic [2:0]         wr_index,
	input  logic [31:0]        wr_data
);
	import hpu_pkg::*;

	typedef struct packed {
		logic             still;
		logic [2:0][31:0] pos;
		logic [2:0]       dneg;
		logic [2:0][32:0] dmag;
	} root_side_t;

	typedef struct packed {
		status_t          status;
		logic [2:0][31:0] pos;
		logic [2:0]       dneg;
	} div_side_t;

	// configuration registers
	logic [31:0] dest_x_q, dest_y_q, dest_z_q;
	logic [30:0] die_dist_q;
	logic [15:0] time_step_q;
	logic [12:0] dt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dest_x_q    <= '0;
			dest_y_q    <= '0;
			dest_z_q    <= 32'd131072;
			die_dist_q  <= 31'd4096;
			time_step_q <= 16'd4096;
		end else if (wr_en) begin
			unique case (reg_index_t'(wr_index))
				REG_DEST_X:    dest_x_q    <= wr_data;
				REG_DEST_Y:    dest_y_q    <= wr_data;
				REG_DEST_Z:    dest_z_q    <= wr_data;
				REG_DIE_DIST:  die_dist_q  <= wr_data[30:0];
				REG_TIME_STEP: time_step_q <= wr_data[15:0];
				default: ;
			endcase
		end
	end

	assign dt = (time_step_q > 16'(STEP_MAX)) ? STEP_MAX : time_step_q[12:0];

	// global advance
	logic en;
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	// front: offsets to destination and magnitudes
	logic [2:0][31:0] pos_in, vel_in, dst;
	logic [2:0][32:0] d_in, dmag_in;
	logic [2:0][31:0] vmag_in;
	logic [2:0]       dneg_in;

	always_comb begin
		pos_in = {in_item.pos_z, in_item.pos_y, in_item.pos_x};
		vel_in = {in_item.vel_z, in_item.vel_y, in_item.vel_x};
		dst    = {dest_z_q, dest_y_q, dest_x_q};
		for (int i = 0; i < 3; i++) begin
			d_in[i]    = {dst[i][31], dst[i]} - {pos_in[i][31], pos_in[i]};
			dneg_in[i] = d_in[i][32];
			dmag_in[i] = d_in[i][32] ? -d_in[i] : d_in[i];
			vmag_in[i] = vel_in[i][31] ? -vel_in[i] : vel_in[i];
		end
	end

	logic             v_s1, v_s2, v_s3;
	logic [2:0][31:0] pos_s1, pos_s2, pos_s3;
	logic [2:0]       dneg_s1, dneg_s2, dneg_s3;
	logic [2:0][32:0] dmag_s1, dmag_s2, dmag_s3;
	logic [2:0][31:0] vmag_s1;
	logic [2:0][63:0] vsq_s2;
	logic [2:0][65:0] dsq_s2;
	logic [63:0]      vsum_s3;
	logic [65:0]      dsum_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// squares, then sums
	always_ff @(posedge clk) begin
		if (en) begin
			pos_s1  <= pos_in;
			dneg_s1 <= dneg_in;
			dmag_s1 <= dmag_in;
			vmag_s1 <= vmag_in;
			for (int i = 0; i < 3; i++) begin
				vsq_s2[i] <= 64'(vmag_s1[i]) * 64'(vmag_s1[i]);
				dsq_s2[i] <= 66'(dmag_s1[i]) * 66'(dmag_s1[i]);
			end
			pos_s2  <= pos_s1;
			dneg_s2 <= dneg_s1;
			dmag_s2 <= dmag_s1;
			vsum_s3 <= vsq_s2[0] + vsq_s2[1] + vsq_s2[2];
			dsum_s3 <= dsq_s2[0] + dsq_s2[1] + dsq_s2[2];
			pos_s3  <= pos_s2;
			dneg_s3 <= dneg_s2;
			dmag_s3 <= dmag_s2;
		end
	end

	// speed and distance roots
	logic [ROOT_W-1:0] spd_root, len_root;

	hpu_root u_spd (
		.clk  (clk),
		.en   (en),
		.rad  ({{(RAD_W-64){1'b0}}, vsum_s3}),
		.root (spd_root)
	);

	hpu_root u_len (
		.clk  (clk),
		.en   (en),
		.rad  ({{(RAD_W-66){1'b0}}, dsum_s3}),
		.root (len_root)
	);

	// side data alongside the roots
	root_side_t           rside_q [ROOT_STEPS];
	logic [ROOT_STEPS-1:0] rv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_q <= '0;
		end else if (en) begin
			rv_q <= {rv_q[ROOT_STEPS-2:0], v_s3};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rside_q[0] <= root_side_t'{still: (vsum_s3 <= STILL_LIMIT), pos: pos_s3,
				dneg: dneg_s3, dmag: dmag_s3};
			for (int k = 1; k < ROOT_STEPS; k++) begin
				rside_q[k] <= rside_q[k-1];
			end
		end
	end

	// travel and numerator products
	root_side_t       rside_end;
	logic [31:0]      spd;
	logic             v_s4;
	logic             still_s4;
	logic [2:0][31:0] pos_s4;
	logic [2:0]       dneg_s4;
	logic [28:0]      travel_s4;
	logic [2:0][NUM_W-1:0] nprod_s4;
	logic [LEN_W-1:0] len_s4;

	assign rside_end = rside_q[ROOT_STEPS-1];
	assign spd       = spd_root[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= rv_q[ROOT_STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		logic [44:0] tprod;
		if (en) begin
			tprod     = 45'(spd) * 45'(dt);
			travel_s4 <= tprod[44:16];
			for (int i = 0; i < 3; i++) begin
				nprod_s4[i] <= NUM_W'(rside_end.dmag[i]) * NUM_W'(spd);
			end
			len_s4   <= len_root[LEN_W-1:0];
			still_s4 <= rside_end.still;
			pos_s4   <= rside_end.pos;
			dneg_s4  <= rside_end.dneg;
		end
	end

	// arrival test
	logic signed [35:0] gap;
	status_t            status_s4;

	always_comb begin
		gap = $signed({2'b00, len_s4}) - $signed({7'b0, travel_s4});
		if (still_s4) begin
			status_s4 = ST_STILL;
		end else if (len_s4 == '0 || gap <= $signed({5'b0, die_dist_q})) begin
			status_s4 = ST_ARRIVED;
		end else begin
			status_s4 = ST_KEPT;
		end
	end

	// re-aim dividers, one per axis
	logic [2:0][DIV_STEPS-1:0] quo;

	for (genvar g = 0; g < 3; g++) begin : g_div
		hpu_div u_div (
			.clk (clk),
			.en  (en),
			.num (nprod_s4[g]),
			.den (len_s4),
			.quo (quo[g])
		);
	end

	div_side_t            dside_q [DIV_STEPS];
	logic [DIV_STEPS-1:0] dv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_q <= '0;
		end else if (en) begin
			dv_q <= {dv_q[DIV_STEPS-2:0], v_s4};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dside_q[0] <= div_side_t'{status: status_s4, pos: pos_s4, dneg: dneg_s4};
			for (int k = 1; k < DIV_STEPS; k++) begin
				dside_q[k] <= dside_q[k-1];
			end
		end
	end

	// signed velocity, step product, output
	div_side_t           dside_end;
	logic                v_s6, v_s7;
	logic [2:0][31:0]    nv_s6, nv_s7;
	logic [2:0][31:0]    pos_s6, pos_s7;
	status_t             status_s6, status_s7;
	logic [2:0][45:0]    step_s7;
	out_item_t           out_q;
	logic                out_v_q;

	assign dside_end = dside_q[DIV_STEPS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6    <= 1'b0;
			v_s7    <= 1'b0;
			out_v_q <= 1'b0;
		end else if (en) begin
			v_s6    <= dv_q[DIV_STEPS-1];
			v_s7    <= v_s6;
			out_v_q <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		logic [2:0][31:0] np;
		logic [33:0]      sum;
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				if (dside_end.dneg[i]) begin
					nv_s6[i] <= (quo[i][31] && quo[i][30:0] != '0) ? 32'h8000_0000 : -quo[i];
				end else begin
					nv_s6[i] <= quo[i][31] ? 32'h7FFF_FFFF : quo[i];
				end
			end
			pos_s6    <= dside_end.pos;
			status_s6 <= dside_end.status;

			for (int i = 0; i < 3; i++) begin
				step_s7[i] <= 46'($signed(nv_s6[i]) * $signed({1'b0, dt}));
			end
			nv_s7     <= nv_s6;
			pos_s7    <= pos_s6;
			status_s7 <= status_s6;

			for (int i = 0; i < 3; i++) begin
				sum   = 34'($signed(pos_s7[i])) + 34'($signed(step_s7[i]) >>> 16);
				np[i] = sat32($signed(sum));
			end
			if (status_s7 == ST_KEPT) begin
				out_q.new_pos_x <= np[0];
				out_q.new_pos_y <= np[1];
				out_q.new_pos_z <= np[2];
				out_q.new_vel_x <= nv_s7[0];
				out_q.new_vel_y <= nv_s7[1];
				out_q.new_vel_z <= nv_s7[2];
			end else begin
				out_q.new_pos_x <= '0;
				out_q.new_pos_y <= '0;
				out_q.new_pos_z <= '0;
				out_q.new_vel_x <= '0;
				out_q.new_vel_y <= '0;
				out_q.new_vel_z <= '0;
			end
			out_q.status <= status_s7;
		end
	end

	assign out_valid = out_v_q;
	assign out_item  = out_q;

	// checks
	a_removed_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status != ST_KEPT |-> out_item.new_pos_x == 0 &&
		out_item.new_vel_x == 0 && out_item.new_pos_z == 0 && out_item.new_vel_z == 0)
		else $error("removed item carries nonzero fields");

	a_hold_stage: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(nv_s6) && $stable(v_s4) && $stable(rv_q))
		else $error("pipeline moved while output stalled");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> v_s1)
		else $error("accepted item lost at entry");

endmodule

// ===== hw/rtl/hpu_root.sv =====
// pipelined square root, one result bit per stage
`timescale 1ns / 1ps
module hpu_root (
	input  logic                       clk,
	input  logic                       en,
	input  logic [hpu_pkg::RAD_W-1:0]  rad,
	output logic [hpu_pkg::ROOT_W-1:0] root
);
	import hpu_pkg::*;

	root_state_t st_q [ROOT_STEPS];

	// digit stages
	always_ff @(posedge clk) begin
		if (en) begin
			st_q[0] <= root_step(root_state_t'{rad: rad, rem: '0, root: '0});
			for (int k = 1; k < ROOT_STEPS; k++) begin
				st_q[k] <= root_step(st_q[k-1]);
			end
		end
	end

	assign root = st_q[ROOT_STEPS-1].root;

endmodule

// ===== hw/rtl/hpu_div.sv =====
// pipelined unsigned divider, one quotient bit per stage
`timescale 1ns / 1ps
module hpu_div (
	input  logic                          clk,
	input  logic                          en,
	input  logic [hpu_pkg::NUM_W-1:0]     num,
	input  logic [hpu_pkg::LEN_W-1:0]     den,
	output logic [hpu_pkg::DIV_STEPS-1:0] quo
);
	import hpu_pkg::*;

	div_state_t st_q [DIV_STEPS];
	div_state_t st_in;

	// upper part of the numerator is the starting remainder
	always_comb begin
		st_in.num = num[DIV_STEPS-1:0];
		st_in.rem = LEN_W'(num[NUM_W-1:DIV_STEPS]);
		st_in.den = den;
		st_in.quo = '0;
	end

	// quotient bit stages
	always_ff @(posedge clk) begin
		if (en) begin
			st_q[0] <= div_step(st_in);
			for (int k = 1; k < DIV_STEPS; k++) begin
				st_q[k] <= div_step(st_q[k-1]);
			end
		end
	end

	assign quo = st_q[DIV_STEPS-1].quo;

endmodule
